@@ rtl/mts_pkg.sv @@
package mts_pkg;

    // Trace geometry
    localparam int TRACE_LEN = 64;
    localparam int IDX_W     = $clog2(TRACE_LEN);

    // Field widths
    localparam int DATA_W    = 32;
    localparam int TOL_W     = 31;
    localparam int CFG_IDX_W = 3;

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic signed [DATA_W-1:0] sample_t;

    localparam idx_t IDX_LAST = idx_t'(TRACE_LEN - 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MARKER_LEVEL   = 3'd0,
        CFG_TOLERANCE      = 3'd1,
        CFG_USE_LAST_MATCH = 3'd2,
        CFG_MIN_START      = 3'd3,
        CFG_MAX_START      = 3'd4
    } cfg_reg_t;

    localparam sample_t MIN_START_RST = sample_t'(32'sh7FFF_FFFF);
    localparam sample_t MAX_START_RST = sample_t'(32'sh8000_0000);

    // Load and drain phases of one trace
    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    // One buffered position: both candidate values
    typedef struct packed {
        sample_t repl;
        sample_t base;
    } pair_t;

    // One result item on its way out
    typedef struct packed {
        sample_t val;
        logic    last;
        sample_t mn;
        sample_t mx;
    } res_t;

endpackage

@@ rtl/mts_ram.sv @@
module mts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/marker_trace_splice_unit.sv @@
// Marker trace splice unit.
// Input channel (in_valid/in_ready) takes one sample position per item: base,
// replacement and marker values plus trace_end. Samples of a trace are written
// into one buffer memory, one item per cycle, while the marker is compared
// with marker_level to record the first or last matching position.
// A trace closes on trace_end or on its TRACE_LEN-th sample; in_ready then
// drops and the buffer is read back, one position per cycle while the output
// stage has room, producing one result item per sample on the output channel
// (out_valid/out_ready). Positions from the match onward carry the replacement
// value. A trace is loaded completely before it is drained: the single buffer
// memory's write port serves loading and its read port serves drain, so no new
// sample is taken until the last read of the trace has been issued.
// A two-entry output stage (output register plus skid) absorbs the read
// latency; a stalled receiver holds the current item and pauses buffer reads.
// Configuration is to be written through cfg_we/cfg_index/cfg_data while idle;
// the block does not enforce this. Writing min_start or max_start also reloads
// the running minimum/maximum.
// Reset clears the trace state and returns registers to their reset values.
module marker_trace_splice_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mts_pkg::DATA_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [mts_pkg::DATA_W-1:0] base_sample,
    input  logic signed [mts_pkg::DATA_W-1:0] replacement_sample,
    input  logic signed [mts_pkg::DATA_W-1:0] marker_sample,
    input  logic                            trace_end,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [mts_pkg::DATA_W-1:0] spliced_sample,
    output logic                            last_of_trace,
    output logic signed [mts_pkg::DATA_W-1:0] running_min,
    output logic signed [mts_pkg::DATA_W-1:0] running_max
);

    import mts_pkg::*;

    // Configuration
    sample_t            marker_level_reg;
    logic [TOL_W-1:0]   tolerance_reg;
    logic               use_last_reg;

    // Trace control
    state_t  state_reg, state_next;
    idx_t    count_reg, count_next;
    idx_t    match_pos_reg, match_pos_next;
    logic    match_seen_reg, match_seen_next;
    idx_t    last_idx_reg, last_idx_next;
    idx_t    rd_idx_reg, rd_idx_next;

    // Read in flight
    logic    rd_pend_reg;
    logic    rd_repl_reg;
    logic    rd_last_reg;
    logic    issue;
    logic    issue_repl;
    logic    issue_last;

    // Running extremes
    sample_t min_reg;
    sample_t max_reg;

    // Output stage
    logic    out_valid_reg;
    logic    skid_valid_reg;
    res_t    out_reg;
    res_t    skid_reg;
    res_t    arr_res;

    logic    in_acc;
    logic    out_take;
    logic [1:0] occ;
    logic    space;

    logic signed [DATA_W:0] diff;
    logic [DATA_W:0]        mag;
    logic                   hit;
    logic                   take_match;

    pair_t   wr_pair;
    pair_t   rd_pair;
    sample_t arr_val;
    sample_t arr_min;
    sample_t arr_max;

    // Buffer memory
    assign wr_pair.repl = replacement_sample;
    assign wr_pair.base = base_sample;

    mts_ram #(
        .WIDTH ($bits(pair_t)),
        .DEPTH (TRACE_LEN)
    ) u_buf (
        .clk   (clk),
        .we    (in_acc),
        .waddr (count_reg),
        .wdata (wr_pair),
        .raddr (rd_idx_reg),
        .rdata (rd_pair)
    );

    // Marker compare, exact in one extra bit
    assign diff = {marker_sample[DATA_W-1], marker_sample}
                - {marker_level_reg[DATA_W-1], marker_level_reg};
    assign mag  = diff[DATA_W] ? (~diff + 1'b1) : diff;
    assign hit  = (mag <= {2'b00, tolerance_reg});
    assign take_match = hit && (use_last_reg || !match_seen_reg);

    assign in_ready = (state_reg == ST_LOAD);
    assign in_acc   = in_valid && in_ready;
    assign out_take = out_valid_reg && out_ready;

    // Issue a read only when the output stage is sure to have room
    assign occ   = {1'b0, out_valid_reg} + {1'b0, skid_valid_reg} + {1'b0, rd_pend_reg};
    assign space = (occ < 2'd2) || ((occ == 2'd2) && out_take);

    assign issue_repl = match_seen_reg && (rd_idx_reg >= match_pos_reg);
    assign issue_last = (rd_idx_reg == last_idx_reg);

    // Next state and trace bookkeeping
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        match_pos_next  = match_pos_reg;
        match_seen_next = match_seen_reg;
        last_idx_next   = last_idx_reg;
        rd_idx_next     = rd_idx_reg;
        issue           = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (take_match)
                    begin
                        match_pos_next  = count_reg;
                        match_seen_next = 1'b1;
                    end
                    if (trace_end || (count_reg == IDX_LAST))
                    begin
                        last_idx_next = count_reg;
                        rd_idx_next   = '0;
                        count_next    = '0;
                        state_next    = ST_DRAIN;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (space)
                begin
                    issue       = 1'b1;
                    rd_idx_next = rd_idx_reg + 1'b1;
                    if (issue_last)
                    begin
                        match_seen_next = 1'b0;
                        match_pos_next  = '0;
                        state_next      = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            match_pos_reg  <= '0;
            match_seen_reg <= 1'b0;
            last_idx_reg   <= '0;
            rd_idx_reg     <= '0;
            rd_pend_reg    <= 1'b0;
            rd_repl_reg    <= 1'b0;
            rd_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            match_pos_reg  <= match_pos_next;
            match_seen_reg <= match_seen_next;
            last_idx_reg   <= last_idx_next;
            rd_idx_reg     <= rd_idx_next;
            rd_pend_reg    <= issue;
            if (issue)
            begin
                rd_repl_reg <= issue_repl;
                rd_last_reg <= issue_last;
            end
        end
    end

    // Select value and fold it into the running extremes
    assign arr_val = rd_repl_reg ? rd_pair.repl : rd_pair.base;
    assign arr_min = (arr_val < min_reg) ? arr_val : min_reg;
    assign arr_max = (arr_val > max_reg) ? arr_val : max_reg;

    assign arr_res.val  = arr_val;
    assign arr_res.last = rd_last_reg;
    assign arr_res.mn   = arr_min;
    assign arr_res.mx   = arr_max;

    // Configuration registers and running extremes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_level_reg <= '0;
            tolerance_reg    <= '0;
            use_last_reg     <= 1'b0;
            min_reg          <= MIN_START_RST;
            max_reg          <= MAX_START_RST;
        end
        else
        begin
            if (rd_pend_reg)
            begin
                min_reg <= arr_min;
                max_reg <= arr_max;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MARKER_LEVEL:   marker_level_reg <= cfg_data;
                    CFG_TOLERANCE:      tolerance_reg    <= cfg_data[TOL_W-1:0];
                    CFG_USE_LAST_MATCH: use_last_reg     <= cfg_data[0];
                    CFG_MIN_START:      min_reg          <= cfg_data;
                    CFG_MAX_START:      max_reg          <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    // Output stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= rd_pend_reg;
            end
            else
            begin
                out_valid_reg <= rd_pend_reg;
            end
        end
        else if (rd_pend_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_reg  <= skid_reg;
                skid_reg <= arr_res;
            end
            else
            begin
                out_reg <= arr_res;
            end
        end
        else if (rd_pend_reg)
        begin
            skid_reg <= arr_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign spliced_sample = out_reg.val;
    assign last_of_trace  = out_reg.last;
    assign running_min    = out_reg.mn;
    assign running_max    = out_reg.mx;

endmodule

@@ rtl/mts_check.sv @@
module mts_check (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            trace_end,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic signed [mts_pkg::DATA_W-1:0] spliced_sample,
    input logic                            last_of_trace,
    input logic signed [mts_pkg::DATA_W-1:0] running_min,
    input logic signed [mts_pkg::DATA_W-1:0] running_max
);

    // Closing item stops intake for the drain
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && trace_end) |=> !in_ready)
    else $error("input still ready after the closing item of a trace");

    // Every emitted value lies inside its running range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (running_min <= spliced_sample) && (spliced_sample <= running_max))
    else $error("emitted sample outside running min/max");

    // Running minimum never grows, maximum never shrinks, across consecutive items of a drain
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) ##1 (out_valid && !in_ready)
        |-> (running_min <= $past(running_min)) && (running_max >= $past(running_max)))
    else $error("running extremes moved the wrong way within a drain");

    // Stalled item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
        (out_valid && $stable(spliced_sample) && $stable(last_of_trace)))
    else $error("stalled result item changed");

endmodule

bind marker_trace_splice_unit mts_check u_mts_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .trace_end      (trace_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .spliced_sample (spliced_sample),
    .last_of_trace  (last_of_trace),
    .running_min    (running_min),
    .running_max    (running_max)
);

@@ tb/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    localparam int      IDLE_LIMIT    = 5000;
    localparam int      SETTLE_CYCLES = 12;
    localparam int      HOLD_CYCLES   = 400;
    localparam int      PHASES        = 5;
    localparam int      PHASE_ITEMS   = 25;
    localparam sample_t S_MAX         = 32'sh7FFF_FFFF;
    localparam sample_t S_MIN         = 32'sh8000_0000;

    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_COMB
    } rx_style_t;

    typedef struct {
        sample_t val;
        logic    last;
        sample_t mn;
        sample_t mx;
    } splice_t;

    logic                 clk;
    logic                 rst_n              = 1'b0;
    logic                 cfg_we             = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index          = '0;
    logic [DATA_W-1:0]    cfg_data           = '0;
    logic                 in_valid           = 1'b0;
    logic                 in_ready;
    sample_t              base_sample        = '0;
    sample_t              replacement_sample = '0;
    sample_t              marker_sample      = '0;
    logic                 trace_end          = 1'b0;
    logic                 out_valid;
    logic                 out_ready          = 1'b0;
    sample_t              spliced_sample;
    logic                 last_of_trace;
    sample_t              running_min;
    sample_t              running_max;

    // Shadow registers and trace state of the splice predictor
    sample_t          marker_lvl;
    logic [TOL_W-1:0] match_tol;
    logic             pick_last;
    sample_t          base_buf [TRACE_LEN];
    sample_t          repl_buf [TRACE_LEN];
    int               fill_cnt;
    int               match_pos;
    logic             match_hit;
    sample_t          low_mark;
    sample_t          high_mark;
    splice_t          expected_splice_q [$];

    // Bookkeeping
    int        mismatches   = 0;
    int        items_sent   = 0;
    int        results_seen = 0;
    int        traces_done  = 0;
    int        forced_ends  = 0;
    int        unmatched    = 0;
    int        cfg_writes   = 0;
    int        burst_left   = 0;
    int        hold_left    = 0;
    int        idle_cycles  = 0;
    rx_style_t rx_style     = RX_STEADY;
    int        rx_span      = 0;
    int        rx_tick      = 0;

    marker_trace_splice_unit u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .base_sample        (base_sample),
        .replacement_sample (replacement_sample),
        .marker_sample      (marker_sample),
        .trace_end          (trace_end),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .spliced_sample     (spliced_sample),
        .last_of_trace      (last_of_trace),
        .running_min        (running_min),
        .running_max        (running_max)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void reset_predictor();
        marker_lvl = '0;
        match_tol  = '0;
        pick_last  = 1'b0;
        fill_cnt   = 0;
        match_pos  = 0;
        match_hit  = 1'b0;
        low_mark   = MIN_START_RST;
        high_mark  = MAX_START_RST;
        for (int i = 0; i < TRACE_LEN; i++)
        begin
            base_buf[i] = '0;
            repl_buf[i] = '0;
        end
    endfunction

    // Buffer one sample; on trace close, queue the spliced trace
    function automatic void predict_splice(sample_t b, sample_t r, sample_t m, logic e);
        longint  mark_gap;
        splice_t res;
        int      pos;
        pos           = fill_cnt;
        base_buf[pos] = b;
        repl_buf[pos] = r;
        // exact difference, no wrap
        mark_gap = longint'(m) - longint'(marker_lvl);
        if (mark_gap < 0)
            mark_gap = -mark_gap;
        if (mark_gap <= longint'(match_tol) && (pick_last || !match_hit))
        begin
            match_pos = pos;
            match_hit = 1'b1;
        end
        fill_cnt = pos + 1;
        if (!e && fill_cnt < TRACE_LEN)
            return;
        if (!e)
            forced_ends++;
        if (!match_hit)
            unmatched++;
        traces_done++;
        for (int i = 0; i < fill_cnt; i++)
        begin
            res.val = (match_hit && i >= match_pos) ? repl_buf[i] : base_buf[i];
            if (res.val < low_mark)
                low_mark = res.val;
            if (res.val > high_mark)
                high_mark = res.val;
            res.last = (i == fill_cnt - 1);
            res.mn   = low_mark;
            res.mx   = high_mark;
            expected_splice_q.push_back(res);
        end
        fill_cnt  = 0;
        match_pos = 0;
        match_hit = 1'b0;
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 7))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return sample_t'($urandom_range(0, 255)) - 128;
            default: return $urandom;
        endcase
    endfunction

    // Marker near the current level often enough to hit the tolerance window
    function automatic sample_t pick_marker();
        longint off;
        case ($urandom_range(0, 5))
            0, 1, 2:
            begin
                off = longint'($urandom) % (longint'(match_tol) + 2);
                if ($urandom_range(0, 1))
                    off = -off;
                return sample_t'(longint'(marker_lvl) + off);
            end
            3:       return marker_lvl;
            default: return $urandom;
        endcase
    endfunction

    function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
        end
    endfunction

    // Write one register and mirror it into the predictor
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_MARKER_LEVEL:   marker_lvl = data;
            CFG_TOLERANCE:      match_tol  = data[TOL_W-1:0];
            CFG_USE_LAST_MATCH: pick_last  = data[0];
            CFG_MIN_START:      low_mark   = data;
            CFG_MAX_START:      high_mark  = data;
            default:            ;
        endcase
    endtask

    // Offer one item, idling in bursts, and predict once it is taken
    task automatic send_sample(sample_t b, sample_t r, sample_t m, logic e);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0)
        begin
            in_valid           <= 1'b0;
            base_sample        <= $urandom;
            replacement_sample <= $urandom;
            marker_sample      <= $urandom;
            trace_end          <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
        end
        in_valid           <= 1'b1;
        base_sample        <= b;
        replacement_sample <= r;
        marker_sample      <= m;
        trace_end          <= e;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        predict_splice(b, r, m, e);
    endtask

    task automatic send_trace(int len, logic end_last);
        for (int i = 0; i < len; i++)
            send_sample(rand_sample(), rand_sample(), pick_marker(),
                        (i == len - 1) ? end_last : 1'b0);
    endtask

    // Stop offering and wait until every queued result has drained
    task automatic settle_block();
        in_valid <= 1'b0;
        while (expected_splice_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    // Default registers: level zero with zero tolerance
    task automatic test_reset_defaults();
        send_sample(S_MAX, S_MIN, 32'sd0, 1'b1);
        send_sample(S_MIN, S_MAX, 32'sd1, 1'b1);
        settle_block();
    endtask

    // Marker difference must not wrap at the ends of the range
    task automatic test_marker_extremes();
        write_cfg(CFG_MARKER_LEVEL, S_MAX);
        write_cfg(CFG_TOLERANCE, 32'hFFFF_FFFF);
        send_sample(S_MAX, S_MIN, S_MIN, 1'b0);
        send_sample(S_MIN, S_MAX, -32'sd1, 1'b0);
        send_sample(32'sd5, -32'sd5, 32'sd0, 1'b0);
        send_sample(-32'sd9, 32'sd9, S_MIN, 1'b1);
        settle_block();
        write_cfg(CFG_MARKER_LEVEL, S_MIN);
        write_cfg(CFG_TOLERANCE, 32'h8000_0000);
        send_sample(rand_sample(), rand_sample(), S_MAX, 1'b0);
        send_sample(rand_sample(), rand_sample(), S_MIN, 1'b1);
        settle_block();
    endtask

    // Same markers under first-match and last-match selection
    task automatic test_match_mode();
        sample_t marks [5];
        marks = '{32'sd95, 32'sd105, 32'sd50, 32'sd106, 32'sd100};
        write_cfg(CFG_MARKER_LEVEL, 32'sd100);
        write_cfg(CFG_TOLERANCE, 32'd5);
        write_cfg(CFG_USE_LAST_MATCH, 32'd0);
        foreach (marks[i])
            send_sample(rand_sample(), rand_sample(), marks[i], i == 4);
        settle_block();
        write_cfg(CFG_USE_LAST_MATCH, 32'hFFFF_FFFF);
        foreach (marks[i])
            send_sample(rand_sample(), rand_sample(), marks[i], i == 4);
        settle_block();
    endtask

    // Start registers reload the running bounds at once; spare indexes do nothing
    task automatic test_start_registers();
        write_cfg(CFG_MIN_START, S_MIN);
        write_cfg(CFG_MAX_START, S_MAX);
        send_sample(32'sd7, 32'sd8, 32'sd0, 1'b0);
        send_sample(-32'sd7, -32'sd8, 32'sd0, 1'b1);
        settle_block();
        write_cfg(CFG_MIN_START, S_MAX);
        write_cfg(CFG_MAX_START, S_MIN);
        for (int k = int'(CFG_MAX_START) + 1; k < (1 << CFG_IDX_W); k++)
            write_cfg(CFG_IDX_W'(k), $urandom);
        send_sample(32'sd0, S_MAX, 32'sd0, 1'b1);
        settle_block();
    endtask

    // Receiver holds off while a full trace and the next one are offered
    task automatic test_receiver_hold();
        hold_left = HOLD_CYCLES;
        send_trace(TRACE_LEN, 1'b0);
        send_trace(16, 1'b1);
        settle_block();
    endtask

    // Random traces under a fresh register setting per phase
    task automatic test_random_traces();
        int      first_item;
        int      len;
        sample_t lvl;
        sample_t tol;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph < 2 ? ph : $urandom_range(0, 4))
                0:       lvl = S_MAX;
                1:       lvl = S_MIN;
                2:       lvl = '0;
                default: lvl = $urandom;
            endcase
            case (ph < 2 ? ph : $urandom_range(0, 3))
                0:       tol = 32'h7FFF_FFFF;
                1:       tol = '0;
                2:       tol = $urandom_range(0, 32'h0003_0000);
                default: tol = $urandom;
            endcase
            tol[DATA_W-1] = 1'($urandom_range(0, 1));
            write_cfg(CFG_MARKER_LEVEL, lvl);
            write_cfg(CFG_TOLERANCE, tol);
            write_cfg(CFG_USE_LAST_MATCH, $urandom);
            if ($urandom_range(0, 1))
                write_cfg(CFG_MIN_START, $urandom_range(0, 1) ? S_MAX : $urandom);
            if ($urandom_range(0, 1))
                write_cfg(CFG_MAX_START, $urandom_range(0, 1) ? S_MIN : $urandom);
            first_item = items_sent;
            while (items_sent - first_item < PHASE_ITEMS)
            begin
                case ($urandom_range(0, 9))
                    0:       len = $urandom_range(TRACE_LEN, TRACE_LEN + 16);
                    1, 2:    len = $urandom_range(13, TRACE_LEN - 1);
                    default: len = $urandom_range(1, 12);
                endcase
                send_trace(len, (len != TRACE_LEN) || $urandom_range(0, 1));
            end
            settle_block();
        end
    endtask

    initial
    begin
        reset_predictor();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_marker_extremes();
        test_match_mode();
        test_start_registers();
        test_receiver_hold();
        test_random_traces();
        $display("Run covered %0d samples in %0d traces: %0d closed at full length, %0d unmatched.",
                 items_sent, traces_done, forced_ends, unmatched);
        $display("Checked %0d spliced results over %0d register writes.",
                 results_seen, cfg_writes);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Receiver stall pattern, with an optional long hold-off
    always @(posedge clk)
    begin
        rx_tick++;
        if (rx_span == 0)
        begin
            rx_style = rx_style_t'($urandom_range(0, 2));
            rx_span  = $urandom_range(20, 200);
        end
        rx_span--;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_style)
                RX_STEADY: out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                default:   out_ready <= (rx_tick % 7) >= 3;
            endcase
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        splice_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_splice_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result: expected none actual %h last %b",
                         $time, spliced_sample, last_of_trace);
            end
            else
            begin
                want = expected_splice_q.pop_front();
                results_seen++;
                check_field("spliced_sample", want.val, spliced_sample);
                check_field("last_of_trace", DATA_W'(want.last), DATA_W'(last_of_trace));
                check_field("running_min", want.mn, running_min);
                check_field("running_max", want.mx, running_max);
            end
        end
    end

    // End the run when no item moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_splice_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
